FILE: design/b58e_pkg.sv
`default_nettype none
// ============================================================================
// b58e_pkg
// Shared sizes, link type and alphabet lookup for the base-58 encoder.
// ============================================================================
package b58e_pkg;

    localparam int MAX_BYTES = 32;
    localparam int MAX_CHARS = 44;
    localparam int RADIX     = 58;

    // digits needed for MAX_BYTES bytes: ceil(8 * bytes / log2(58)), rounded up
    localparam int DIGIT_CAP = (MAX_BYTES * 8000 + 5856) / 5857;

    localparam int COUNT_W = $clog2(MAX_BYTES + 1);
    localparam int ADDR_W  = $clog2(DIGIT_CAP);
    localparam int PASS_W  = $clog2(DIGIT_CAP + 1);
    localparam int ND_W    = $clog2(DIGIT_CAP + 1);
    localparam int SUM_W   = $clog2(MAX_BYTES + DIGIT_CAP + MAX_CHARS + 1);

    // floor(2^15 / 58); estimate is low by at most one
    localparam int RECIP_SHIFT = 15;
    localparam int RECIP       = (1 << RECIP_SHIFT) / RADIX;

    localparam logic [8*RADIX-1:0] ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef struct packed {
        logic       tok;
        logic [5:0] rem;
    } link_t;

    function automatic logic [6:0] alpha_char(input logic [5:0] d);
        logic [5:0] idx;
        idx = (d < 6'(RADIX)) ? d : 6'd0;
        return ALPHABET[8 * (RADIX - 1 - int'(idx)) +: 7];
    endfunction

endpackage
`default_nettype wire

FILE: design/base58_encoder_unit.sv
`default_nettype none
// ============================================================================
// base58_encoder_unit
// Byte string in, base-58 alphabet characters out, most significant first.
// ============================================================================
//  channel  | dir | tdata            | tlast      | tuser
//  s_axis   | in  | [7:0] data_byte  | last_byte  | -
//  m_axis   | out | [6:0] char_code  | last_char  | overflow
//
//  Input bytes are taken one per cycle while idle; tready drops after last_byte.
//  Conversion: DIGIT_CAP passes enter the cell row one per cycle and each
//  crosses all MAX_BYTES cells, leaving one digit at the far end.
//  Each character then goes through digit RAM read, format and present in
//  turn. m_tvalid holds with its request until m_tready; the next character
//  is not read before that. Reset clears control and output registers only.
// ============================================================================
module base58_encoder_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output      logic       s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,
    output      logic       m_tvalid,
    input  wire logic       m_tready,
    output      logic [7:0] m_tdata,   // [6:0] char_code, [7] zero
    output      logic       m_tlast,
    output      logic       m_tuser    // [0] overflow
);

    localparam int CW = b58e_pkg::COUNT_W;
    localparam int AW = b58e_pkg::ADDR_W;
    localparam int PW = b58e_pkg::PASS_W;
    localparam int NW = b58e_pkg::ND_W;
    localparam int SW = b58e_pkg::SUM_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CONV,
        S_SIZE,
        S_FETCH,
        S_FORM,
        S_SHOW
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   lead_reg, lead_next;
    logic            allzero_reg, allzero_next;
    logic            ovf_reg, ovf_next;
    logic [PW-1:0]   pass_reg, pass_next;
    logic [AW-1:0]   dig_reg, dig_next;
    logic [NW-1:0]   nd_reg, nd_next;
    logic [SW-1:0]   total_reg, total_next;
    logic [SW-1:0]   k_reg, k_next;
    logic            valid_reg, valid_next;
    logic [6:0]      char_reg, char_next;
    logic            last_reg, last_next;
    logic            user_reg, user_next;

    logic [5:0]      digit_mem [b58e_pkg::DIGIT_CAP];
    logic [5:0]      rd_data_reg;
    logic            rd_en;
    logic [SW-1:0]   rd_pos;
    logic            wr_en;

    logic            accept;
    logic            store;
    logic            row_load;
    logic            row_clear;
    logic            pass_start;
    logic [SW-1:0]   sum;
    logic [5:0]      digit;
    b58e_pkg::link_t digit_out;

    b58e_cell_row u_row (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (row_load),
        .clear      (row_clear),
        .new_byte   (s_tdata),
        .pass_start (pass_start),
        .digit_out  (digit_out)
    );

    assign s_tready  = (state_reg == S_LOAD);
    assign accept    = s_tvalid && s_tready;
    assign store     = (count_reg < CW'(b58e_pkg::MAX_BYTES));
    assign row_load  = accept && store;
    assign row_clear = (count_reg == '0);
    assign pass_start = (state_reg == S_CONV) && (pass_reg < PW'(b58e_pkg::DIGIT_CAP));
    assign wr_en     = (state_reg == S_CONV) && digit_out.tok;
    assign sum       = SW'(lead_reg) + SW'(nd_reg);
    assign rd_pos    = sum - SW'(1) - k_reg;
    assign rd_en     = (state_reg == S_FETCH) && (k_reg >= SW'(lead_reg));
    assign digit     = (k_reg < SW'(lead_reg)) ? 6'd0 : rd_data_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        lead_next    = lead_reg;
        allzero_next = allzero_reg;
        ovf_next     = ovf_reg;
        pass_next    = pass_reg;
        dig_next     = dig_reg;
        nd_next      = nd_reg;
        total_next   = total_reg;
        k_next       = k_reg;
        valid_next   = valid_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        user_next    = user_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (store)
                    begin
                        count_next = count_reg + CW'(1);
                        if (allzero_reg && (s_tdata == 8'd0))
                            lead_next = lead_reg + CW'(1);
                        else
                            allzero_next = 1'b0;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        pass_next  = '0;
                        dig_next   = '0;
                        nd_next    = '0;
                        state_next = S_CONV;
                    end
                end
            end
            S_CONV:
            begin
                if (pass_start)
                    pass_next = pass_reg + PW'(1);
                if (digit_out.tok)
                begin
                    if (digit_out.rem != 6'd0)
                        nd_next = NW'(dig_reg) + NW'(1);
                    dig_next = dig_reg + AW'(1);
                    if (dig_reg == AW'(b58e_pkg::DIGIT_CAP - 1))
                        state_next = S_SIZE;
                end
            end
            S_SIZE:
            begin
                total_next = (sum > SW'(b58e_pkg::MAX_CHARS)) ?
                             SW'(b58e_pkg::MAX_CHARS) : sum;
                k_next     = '0;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                state_next = S_FORM;
            end
            S_FORM:
            begin
                char_next  = b58e_pkg::alpha_char(digit);
                last_next  = (k_reg + SW'(1) == total_reg);
                user_next  = ovf_reg;
                valid_next = 1'b1;
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                if (m_tready)
                begin
                    valid_next = 1'b0;
                    if (last_reg)
                    begin
                        count_next   = '0;
                        lead_next    = '0;
                        allzero_next = 1'b1;
                        ovf_next     = 1'b0;
                        state_next   = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + SW'(1);
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            lead_reg    <= '0;
            allzero_reg <= 1'b1;
            ovf_reg     <= 1'b0;
            pass_reg    <= '0;
            dig_reg     <= '0;
            nd_reg      <= '0;
            total_reg   <= '0;
            k_reg       <= '0;
            valid_reg   <= 1'b0;
            char_reg    <= '0;
            last_reg    <= 1'b0;
            user_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            lead_reg    <= lead_next;
            allzero_reg <= allzero_next;
            ovf_reg     <= ovf_next;
            pass_reg    <= pass_next;
            dig_reg     <= dig_next;
            nd_reg      <= nd_next;
            total_reg   <= total_next;
            k_reg       <= k_next;
            valid_reg   <= valid_next;
            char_reg    <= char_next;
            last_reg    <= last_next;
            user_reg    <= user_next;
        end
    end

    // digit RAM: written lsd first during conversion, read msd first
    always_ff @(posedge clk)
    begin
        if (wr_en)
            digit_mem[dig_reg] <= digit_out.rem;
        if (rd_en)
            rd_data_reg <= digit_mem[rd_pos[AW-1:0]];
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule
`default_nettype wire

FILE: design/b58e_cell.sv
`default_nettype none
// ============================================================================
// b58e_cell
// One byte of the dividend; one long-division step by 58 per pass token.
// ============================================================================
module b58e_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire logic [7:0]           shift_in,
    output      logic [7:0]           work,
    input  wire b58e_pkg::link_t      link_in,
    output      b58e_pkg::link_t      link_out
);

    logic [7:0]  work_reg;
    logic [5:0]  rem_reg;
    logic        tok_reg;

    logic [13:0] t;
    logic [23:0] prod;
    logic [7:0]  q_est;
    logic [6:0]  r_est;
    logic [7:0]  q;
    logic [5:0]  r;

    always_comb
    begin
        t     = {link_in.rem, work_reg};
        prod  = 24'(t) * 24'(b58e_pkg::RECIP);
        q_est = 8'(prod >> b58e_pkg::RECIP_SHIFT);
        r_est = 7'(t - 14'(q_est) * 14'(b58e_pkg::RADIX));
        if (r_est >= 7'(b58e_pkg::RADIX))
        begin
            q = q_est + 8'd1;
            r = 6'(r_est - 7'(b58e_pkg::RADIX));
        end
        else
        begin
            q = q_est;
            r = r_est[5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= 1'b0;
        else
            tok_reg <= link_in.tok;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            work_reg <= shift_in;
        else if (link_in.tok)
            work_reg <= q;
        rem_reg <= r;
    end

    assign work         = work_reg;
    assign link_out.tok = tok_reg;
    assign link_out.rem = rem_reg;

endmodule
`default_nettype wire

FILE: design/b58e_cell_row.sv
`default_nettype none
// ============================================================================
// b58e_cell_row
// Row of division cells, most significant byte in cell 0. Bytes shift in from
// the far end; remainders ripple toward it one cell per cycle.
// ============================================================================
module b58e_cell_row (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire logic                 clear,
    input  wire logic [7:0]           new_byte,
    input  wire logic                 pass_start,
    output      b58e_pkg::link_t      digit_out
);

    localparam int N = b58e_pkg::MAX_BYTES;

    logic [7:0]      work [N];
    logic [7:0]      shift [N];
    b58e_pkg::link_t links [N+1];

    assign links[0].tok = pass_start;
    assign links[0].rem = 6'd0;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            if (i == N - 1)
            begin : g_tail
                assign shift[i] = new_byte;
            end
            else
            begin : g_body
                assign shift[i] = clear ? 8'd0 : work[i+1];
            end

            b58e_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .load     (load),
                .shift_in (shift[i]),
                .work     (work[i]),
                .link_in  (links[i]),
                .link_out (links[i+1])
            );
        end
    endgenerate

    assign digit_out = links[N];

endmodule
`default_nettype wire
